>>> hw/rtl/hsv2rgb_pkg.sv
// Package for the HSV to RGB converter: sector codes, stage payload types
// and the arithmetic constants shared by the pipeline stages.
// No dependencies.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam logic [7:0] SECT1 = 8'd43;
  localparam logic [7:0] SECT2 = 8'd85;
  localparam logic [7:0] SECT3 = 8'd128;
  localparam logic [7:0] SECT4 = 8'd171;
  localparam logic [7:0] SECT5 = 8'd213;
  localparam logic [7:0] FULL = 8'd255;
  localparam logic [7:0] SAT_KNEE = 8'd128;

  // Reciprocal of 43 scaled by 2^20, rounded up; exact for all ramp inputs.
  localparam logic [14:0] RAMP_RECIP = 15'd24386;
  localparam int RAMP_SHIFT = 20;
  localparam logic [8:0] RAMP_MAX = 9'd498;

  // Named by the channel held at full, then the channel that ramps.
  typedef enum logic [2:0] {
    SEC_RED_GREEN,
    SEC_RED_BLUE,
    SEC_BLUE_RED,
    SEC_BLUE_GREEN,
    SEC_GREEN_BLUE,
    SEC_GREEN_RED
  } sector_t;

  typedef struct packed {
    sector_t    sector;
    logic [6:0] offset;
    logic [8:0] weight;
    logic [7:0] brightness;
  } sect_stage_t;

  typedef struct packed {
    sector_t    sector;
    logic [8:0] ramp;
    logic [8:0] weight;
    logic [7:0] brightness;
  } ramp_stage_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] weight;
  } scale_stage_t;

endpackage

>>> hw/rtl/hsv2rgb_to_rgb_8bit_unit.sv
// Top level of the 8-bit HSV to RGB converter: four register stages.
// An accepted transaction passes the sector, ramp, scale and blend registers in order.
// Throughput: one transaction per cycle while rgb_stall is low; each multiplier is
// used once per transaction. A downstream stall backs up stage by stage; hsv_stall
// rises only when all four stages are full. Synchronous reset empties the pipeline.
// Depends on hsv2rgb_pkg and the four stage modules.
`timescale 1ns / 1ps

module hsv_to_rgb_8bit_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       hsv_valid,
  output logic       hsv_stall,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  output logic       rgb_valid,
  input  logic       rgb_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic sect_ready;
  logic sect_valid;
  logic ramp_ready;
  logic ramp_valid;
  logic scale_ready;
  logic scale_valid;
  logic blend_ready;
  hsv2rgb_pkg::sect_stage_t sect_data;
  hsv2rgb_pkg::ramp_stage_t ramp_data;
  hsv2rgb_pkg::scale_stage_t scale_data;

  assign hsv_stall = !sect_ready;

  hsv2rgb_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .prev_valid (hsv_valid),
    .ready      (sect_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .valid      (sect_valid),
    .next_ready (ramp_ready),
    .data       (sect_data)
  );

  hsv2rgb_ramp u_ramp (
    .clk        (clk),
    .rst        (rst),
    .prev_valid (sect_valid),
    .ready      (ramp_ready),
    .prev_data  (sect_data),
    .valid      (ramp_valid),
    .next_ready (scale_ready),
    .data       (ramp_data)
  );

  hsv2rgb_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .prev_valid (ramp_valid),
    .ready      (scale_ready),
    .prev_data  (ramp_data),
    .valid      (scale_valid),
    .next_ready (blend_ready),
    .data       (scale_data)
  );

  hsv2rgb_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .prev_valid (scale_valid),
    .ready      (blend_ready),
    .prev_data  (scale_data),
    .valid      (rgb_valid),
    .next_ready (!rgb_stall),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && !hsv_stall) |=> sect_valid)
    else $error("accepted transaction did not reach the first stage");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    hsv_stall |-> (sect_valid && ramp_valid && scale_valid && rgb_valid && rgb_stall))
    else $error("input stalled while the pipeline had room");

  a_output_advances: assert property (@(posedge clk) disable iff (rst)
    (scale_valid && !rgb_stall) |=> rgb_valid)
    else $error("ready result did not reach the output");

endmodule

>>> hw/rtl/hsv2rgb_sector.sv
// First pipeline stage: hue rotation, sector decode, ramp offset and the
// saturation weight. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_sector (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      prev_valid,
  output logic                      ready,
  input  logic [7:0]                hue,
  input  logic [7:0]                saturation,
  input  logic [7:0]                brightness,
  output logic                      valid,
  input  logic                      next_ready,
  output hsv2rgb_pkg::sect_stage_t  data
);

  logic [7:0] h;
  hsv2rgb_pkg::sect_stage_t data_next;

  assign ready = !valid || next_ready;
  assign h = hue - hsv2rgb_pkg::SECT1;

  always_comb begin
    data_next.brightness = brightness;
    if (saturation > hsv2rgb_pkg::SAT_KNEE) begin
      data_next.weight = {1'b0, saturation} + 9'd1;
    end else begin
      data_next.weight = {1'b0, saturation};
    end
    if (h < hsv2rgb_pkg::SECT1) begin
      data_next.sector = hsv2rgb_pkg::SEC_RED_GREEN;
      data_next.offset = h[6:0];
    end else if (h < hsv2rgb_pkg::SECT2) begin
      data_next.sector = hsv2rgb_pkg::SEC_RED_BLUE;
      data_next.offset = h[6:0];
    end else if (h < hsv2rgb_pkg::SECT3) begin
      data_next.sector = hsv2rgb_pkg::SEC_BLUE_RED;
      data_next.offset = 7'(hsv2rgb_pkg::SECT3 - h);
    end else if (h < hsv2rgb_pkg::SECT4) begin
      data_next.sector = hsv2rgb_pkg::SEC_BLUE_GREEN;
      data_next.offset = 7'(h - hsv2rgb_pkg::SECT3);
    end else if (h < hsv2rgb_pkg::SECT5) begin
      data_next.sector = hsv2rgb_pkg::SEC_GREEN_BLUE;
      data_next.offset = 7'(hsv2rgb_pkg::SECT5 - h);
    end else begin
      data_next.sector = hsv2rgb_pkg::SEC_GREEN_RED;
      data_next.offset = 7'(h - hsv2rgb_pkg::SECT5);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && prev_valid) begin
      data <= data_next;
    end
  end

endmodule

>>> hw/rtl/hsv2rgb_ramp.sv
// Second pipeline stage: ramp value (offset * 255) / 43 through a
// reciprocal multiply. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_ramp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      prev_valid,
  output logic                      ready,
  input  hsv2rgb_pkg::sect_stage_t  prev_data,
  output logic                      valid,
  input  logic                      next_ready,
  output hsv2rgb_pkg::ramp_stage_t  data
);

  logic [14:0] scaled_off;
  logic [29:0] prod;
  hsv2rgb_pkg::ramp_stage_t data_next;

  assign ready = !valid || next_ready;
  assign scaled_off = {prev_data.offset, 8'b0} - {8'b0, prev_data.offset};
  assign prod = 30'(scaled_off) * 30'(hsv2rgb_pkg::RAMP_RECIP);

  always_comb begin
    data_next.sector = prev_data.sector;
    data_next.ramp = prod[hsv2rgb_pkg::RAMP_SHIFT +: 9];
    data_next.weight = prev_data.weight;
    data_next.brightness = prev_data.brightness;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && prev_valid) begin
      data <= data_next;
    end
  end

  a_ramp_range: assert property (@(posedge clk) disable iff (rst)
    (ready && prev_valid) |=> (data.ramp <= hsv2rgb_pkg::RAMP_MAX))
    else $error("ramp value out of range");

endmodule

>>> hw/rtl/hsv2rgb_scale.sv
// Third pipeline stage: channel assignment by sector and brightness
// scaling. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_scale (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       prev_valid,
  output logic                       ready,
  input  hsv2rgb_pkg::ramp_stage_t   prev_data,
  output logic                       valid,
  input  logic                       next_ready,
  output hsv2rgb_pkg::scale_stage_t  data
);

  logic [7:0] red_raw;
  logic [7:0] green_raw;
  logic [7:0] blue_raw;
  logic [15:0] red_prod;
  logic [15:0] green_prod;
  logic [15:0] blue_prod;
  hsv2rgb_pkg::scale_stage_t data_next;

  assign ready = !valid || next_ready;

  always_comb begin
    red_raw = 8'd0;
    green_raw = 8'd0;
    blue_raw = 8'd0;
    case (prev_data.sector)
      hsv2rgb_pkg::SEC_RED_GREEN: begin
        red_raw = hsv2rgb_pkg::FULL;
        green_raw = hsv2rgb_pkg::FULL - prev_data.ramp[7:0];
      end
      hsv2rgb_pkg::SEC_RED_BLUE: begin
        red_raw = hsv2rgb_pkg::FULL;
        blue_raw = 8'(prev_data.ramp - {1'b0, hsv2rgb_pkg::FULL});
      end
      hsv2rgb_pkg::SEC_BLUE_RED: begin
        blue_raw = hsv2rgb_pkg::FULL;
        red_raw = prev_data.ramp[7:0];
      end
      hsv2rgb_pkg::SEC_BLUE_GREEN: begin
        blue_raw = hsv2rgb_pkg::FULL;
        green_raw = prev_data.ramp[7:0];
      end
      hsv2rgb_pkg::SEC_GREEN_BLUE: begin
        green_raw = hsv2rgb_pkg::FULL;
        blue_raw = prev_data.ramp[7:0];
      end
      hsv2rgb_pkg::SEC_GREEN_RED: begin
        green_raw = hsv2rgb_pkg::FULL;
        red_raw = prev_data.ramp[7:0];
      end
      default: begin
        red_raw = 8'd0;
      end
    endcase
  end

  assign red_prod = 16'(red_raw) * 16'(prev_data.brightness);
  assign green_prod = 16'(green_raw) * 16'(prev_data.brightness);
  assign blue_prod = 16'(blue_raw) * 16'(prev_data.brightness);

  always_comb begin
    data_next.red = red_prod[15:8];
    data_next.green = green_prod[15:8];
    data_next.blue = blue_prod[15:8];
    data_next.weight = prev_data.weight;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && prev_valid) begin
      data <= data_next;
    end
  end

endmodule

>>> hw/rtl/hsv2rgb_blend.sv
// Last pipeline stage: blend toward full by the saturation weight; this
// stage is the output register. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_blend (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       prev_valid,
  output logic                       ready,
  input  hsv2rgb_pkg::scale_stage_t  prev_data,
  output logic                       valid,
  input  logic                       next_ready,
  output logic [7:0]                 red,
  output logic [7:0]                 green,
  output logic [7:0]                 blue
);

  logic [8:0] inv_weight;
  logic [16:0] base;
  logic [16:0] red_sum;
  logic [16:0] green_sum;
  logic [16:0] blue_sum;

  assign ready = !valid || next_ready;
  assign inv_weight = 9'd256 - prev_data.weight;
  assign base = {inv_weight, 8'b0} - {8'b0, inv_weight};
  assign red_sum = 17'(prev_data.red) * 17'(prev_data.weight) + base;
  assign green_sum = 17'(prev_data.green) * 17'(prev_data.weight) + base;
  assign blue_sum = 17'(prev_data.blue) * 17'(prev_data.weight) + base;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && prev_valid) begin
      red <= red_sum[15:8];
      green <= green_sum[15:8];
      blue <= blue_sum[15:8];
    end
  end

  a_white_at_zero_sat: assert property (@(posedge clk) disable iff (rst)
    (ready && prev_valid && prev_data.weight == 9'd0) |=>
    (red == hsv2rgb_pkg::FULL && green == hsv2rgb_pkg::FULL &&
     blue == hsv2rgb_pkg::FULL))
    else $error("zero saturation did not give white");

endmodule

>>> sim/hsv_to_rgb_8bit_checker.sv
// Checker for the 8-bit HSV to RGB converter: it watches both channels, predicts
// the color of each accepted transaction and compares the results in order.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv_to_rgb_8bit_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       hsv_valid,
  input  logic       hsv_stall,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  input  logic       rgb_valid,
  input  logic       rgb_stall,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  rgb_t rgb_expected[$];

  function automatic int unsigned sector_ramp(input int unsigned offset);
    return (offset * hsv2rgb_pkg::FULL) / hsv2rgb_pkg::SECT1;
  endfunction

  function automatic logic [7:0] scale_and_blend(input int unsigned level,
                                                 input int unsigned value,
                                                 input int unsigned weight);
    int unsigned scaled;
    scaled = (level * value) >> 8;
    return 8'((scaled * weight + hsv2rgb_pkg::FULL * (256 - weight)) >> 8);
  endfunction

  function automatic rgb_t convert_hsv(input logic [7:0] h_in, input logic [7:0] s_in,
                                       input logic [7:0] v_in);
    logic [7:0]           rotated;
    int unsigned          h;
    int unsigned          r;
    int unsigned          g;
    int unsigned          b;
    int unsigned          weight;
    hsv2rgb_pkg::sector_t sector;
    rgb_t                 rgb;
    rotated = h_in - hsv2rgb_pkg::SECT1;
    h = rotated;
    r = 0;
    g = 0;
    b = 0;
    if (rotated < hsv2rgb_pkg::SECT1) sector = hsv2rgb_pkg::SEC_RED_GREEN;
    else if (rotated < hsv2rgb_pkg::SECT2) sector = hsv2rgb_pkg::SEC_RED_BLUE;
    else if (rotated < hsv2rgb_pkg::SECT3) sector = hsv2rgb_pkg::SEC_BLUE_RED;
    else if (rotated < hsv2rgb_pkg::SECT4) sector = hsv2rgb_pkg::SEC_BLUE_GREEN;
    else if (rotated < hsv2rgb_pkg::SECT5) sector = hsv2rgb_pkg::SEC_GREEN_BLUE;
    else sector = hsv2rgb_pkg::SEC_GREEN_RED;
    case (sector)
      hsv2rgb_pkg::SEC_RED_GREEN: begin
        r = hsv2rgb_pkg::FULL;
        g = hsv2rgb_pkg::FULL - sector_ramp(h);
      end
      hsv2rgb_pkg::SEC_RED_BLUE: begin
        r = hsv2rgb_pkg::FULL;
        b = sector_ramp(h) - hsv2rgb_pkg::FULL;
      end
      hsv2rgb_pkg::SEC_BLUE_RED: begin
        b = hsv2rgb_pkg::FULL;
        r = sector_ramp(hsv2rgb_pkg::SECT3 - h);
      end
      hsv2rgb_pkg::SEC_BLUE_GREEN: begin
        b = hsv2rgb_pkg::FULL;
        g = sector_ramp(h - hsv2rgb_pkg::SECT3);
      end
      hsv2rgb_pkg::SEC_GREEN_BLUE: begin
        g = hsv2rgb_pkg::FULL;
        b = sector_ramp(hsv2rgb_pkg::SECT5 - h);
      end
      default: begin
        g = hsv2rgb_pkg::FULL;
        r = sector_ramp(h - hsv2rgb_pkg::SECT5);
      end
    endcase
    weight = s_in;
    if (s_in > hsv2rgb_pkg::SAT_KNEE) weight = weight + 1;
    rgb.red = scale_and_blend(r, v_in, weight);
    rgb.green = scale_and_blend(g, v_in, weight);
    rgb.blue = scale_and_blend(b, v_in, weight);
    return rgb;
  endfunction

  task automatic check_channel(input string channel, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, channel, want, got);
    end
  endtask

  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      rgb_expected.delete();
    end else begin
      if (hsv_valid && !hsv_stall)
        rgb_expected.push_back(convert_hsv(hue, saturation, brightness));
      if (rgb_valid && !rgb_stall) begin
        if (rgb_expected.size() == 0) begin
          errors++;
          $display("%0t: expected no transaction, got red %0d green %0d blue %0d",
                   $time, red, green, blue);
        end else begin
          want = rgb_expected.pop_front();
          check_channel("red", want.red, red);
          check_channel("green", want.green, green);
          check_channel("blue", want.blue, blue);
        end
      end
    end
    pending = rgb_expected.size();
  end

endmodule

>>> sim/tb_hsv_to_rgb_8bit_unit.sv
// Testbench top for the 8-bit HSV to RGB converter: clock, reset, stimulus with
// random idling and stalls, and the verdict.
// Depends on hsv2rgb_pkg, hsv_to_rgb_8bit_unit and hsv_to_rgb_8bit_checker.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_8bit_unit;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       hsv_valid = 1'b0;
  logic       hsv_stall;
  logic [7:0] hue = 8'd0;
  logic [7:0] saturation = 8'd0;
  logic [7:0] brightness = 8'd0;
  logic       rgb_valid;
  logic       rgb_stall = 1'b0;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycles = 0;
  int errors;
  int pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hsv_to_rgb_8bit_unit dut (
    .clk(clk),
    .rst(rst),
    .hsv_valid(hsv_valid),
    .hsv_stall(hsv_stall),
    .hue(hue),
    .saturation(saturation),
    .brightness(brightness),
    .rgb_valid(rgb_valid),
    .rgb_stall(rgb_stall),
    .red(red),
    .green(green),
    .blue(blue)
  );

  hsv_to_rgb_8bit_checker checker_i (
    .clk(clk),
    .rst(rst),
    .hsv_valid(hsv_valid),
    .hsv_stall(hsv_stall),
    .hue(hue),
    .saturation(saturation),
    .brightness(brightness),
    .rgb_valid(rgb_valid),
    .rgb_stall(rgb_stall),
    .red(red),
    .green(green),
    .blue(blue),
    .errors(errors),
    .pending(pending)
  );

  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rgb_stall <= 1'b1;
    end else begin
      rgb_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic offer_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
    while ($urandom_range(99) < idle_pct) begin
      hsv_valid <= 1'b0;
      @(posedge clk);
    end
    hsv_valid <= 1'b1;
    hue <= h;
    saturation <= s;
    brightness <= v;
    @(posedge clk);
    while (hsv_stall) @(posedge clk);
  endtask

  function automatic logic [7:0] hue_near_boundary();
    logic [7:0] bound;
    case ($urandom_range(5))
      0: bound = hsv2rgb_pkg::SECT1;
      1: bound = hsv2rgb_pkg::SECT1 + hsv2rgb_pkg::SECT1;
      2: bound = hsv2rgb_pkg::SECT1 + hsv2rgb_pkg::SECT2;
      3: bound = hsv2rgb_pkg::SECT1 + hsv2rgb_pkg::SECT3;
      4: bound = hsv2rgb_pkg::SECT1 + hsv2rgb_pkg::SECT4;
      default: bound = hsv2rgb_pkg::SECT1 + hsv2rgb_pkg::SECT5;
    endcase
    return bound + 8'($urandom_range(2)) - 8'd1;
  endfunction

  function automatic logic [7:0] saturation_near_knee();
    case ($urandom_range(4))
      0: return 8'd0;
      1: return hsv2rgb_pkg::SAT_KNEE - 8'd1;
      2: return hsv2rgb_pkg::SAT_KNEE;
      3: return hsv2rgb_pkg::SAT_KNEE + 8'd1;
      default: return hsv2rgb_pkg::FULL;
    endcase
  endfunction

  task automatic run_random(input int count, input int idle, input int stall);
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) begin
      h = ($urandom_range(3) == 0) ? hue_near_boundary() : 8'($urandom);
      s = ($urandom_range(3) == 0) ? saturation_near_knee() : 8'($urandom);
      v = ($urandom_range(7) == 0) ? 8'($urandom_range(1) * 255) : 8'($urandom);
      offer_pixel(h, s, v);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    offer_pixel(8'd0, 8'd255, 8'd255);
    offer_pixel(8'd42, 8'd255, 8'd255);
    offer_pixel(8'd43, 8'd255, 8'd255);
    offer_pixel(8'd44, 8'd255, 8'd255);
    offer_pixel(8'd85, 8'd255, 8'd255);
    offer_pixel(8'd86, 8'd255, 8'd255);
    offer_pixel(8'd127, 8'd255, 8'd255);
    offer_pixel(8'd128, 8'd255, 8'd255);
    offer_pixel(8'd170, 8'd255, 8'd255);
    offer_pixel(8'd171, 8'd255, 8'd255);
    offer_pixel(8'd213, 8'd255, 8'd255);
    offer_pixel(8'd214, 8'd255, 8'd255);
    offer_pixel(8'd255, 8'd255, 8'd255);
    offer_pixel(8'd0, 8'd0, 8'd255);
    offer_pixel(8'd100, 8'd128, 8'd200);
    offer_pixel(8'd100, 8'd129, 8'd200);
    offer_pixel(8'd200, 8'd127, 8'd200);
    offer_pixel(8'd255, 8'd255, 8'd0);
    offer_pixel(8'd0, 8'd0, 8'd0);
    offer_pixel(8'd255, 8'd0, 8'd0);
    offer_pixel(8'd170, 8'd170, 8'd85);
    offer_pixel(8'd85, 8'd85, 8'd170);
    offer_pixel(8'd1, 8'd1, 8'd1);
    offer_pixel(8'd254, 8'd254, 8'd254);
    run_random(170, 0, 0);
    run_random(170, 52, 0);
    run_random(170, 0, 52);
    hold_requests++;
    run_random(40, 0, 0);
    run_random(170, 25, 25);
    hsv_valid <= 1'b0;
    stall_pct = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
